### sv/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants for the touch gesture classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

   // Coordinate width is fixed by the payload layout.
   localparam int TGC_COORD_BITS = 12;
   // Default hold-timer width.
   localparam int TGC_TIMER_BITS = 16;

   localparam int TGC_SWIPE_BITS = 12;
   localparam int TGC_HOLD_BITS  = 16;
   localparam int TGC_CSR_BITS   = 16;

   // Register file indexes
   localparam logic TGC_CSR_SWIPE_DISTANCE = 1'b0;
   localparam logic TGC_CSR_HOLD_TICKS     = 1'b1;

   localparam logic [TGC_SWIPE_BITS-1:0] TGC_SWIPE_RESET = 12'd50;
   localparam logic [TGC_HOLD_BITS-1:0]  TGC_HOLD_RESET  = 16'd12;

   // Event kinds
   localparam logic [1:0] TGC_CMD_BEGIN = 2'd0;
   localparam logic [1:0] TGC_CMD_MOVE  = 2'd1;
   localparam logic [1:0] TGC_CMD_END   = 2'd2;
   localparam logic [1:0] TGC_CMD_TICK  = 2'd3;

   // Gesture codes
   localparam logic [2:0] TGC_GEST_HOLD  = 3'd0;
   localparam logic [2:0] TGC_GEST_TAP   = 3'd1;
   localparam logic [2:0] TGC_GEST_ENDED = 3'd2;
   localparam logic [2:0] TGC_GEST_UP    = 3'd3;
   localparam logic [2:0] TGC_GEST_DOWN  = 3'd4;

   typedef struct packed {
      logic [1:0]                cmd;
      logic [TGC_COORD_BITS-1:0] x_pos;
      logic [TGC_COORD_BITS-1:0] y_pos;
   } tgc_req_type;

   typedef struct packed {
      logic [2:0]                gesture;
      logic [TGC_COORD_BITS-1:0] start_x;
      logic [TGC_COORD_BITS-1:0] start_y;
      logic [TGC_COORD_BITS-1:0] end_x;
      logic [TGC_COORD_BITS-1:0] end_y;
   } tgc_rsp_type;

endpackage

`default_nettype wire

### sv/touch_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top
// Single-finger gesture recognizer: begin/move/end/tick in, gestures out.
// ----------------------------------------------------------------------------
//
//   channel  | ports                         | direction | payload
//   ---------+-------------------------------+-----------+-------------------
//   request  | req_valid, req_stall, req_data| in        | cmd, x_pos, y_pos
//   response | rsp_valid, rsp_stall, rsp_data| out       | gesture, start/end
//   csr      | csr_wr_en, csr_index, csr_wdata| in       | swipe, hold ticks
//
// One transaction per clock unless req_stall is high. Touch state and the
// response register update at the edge that accepts the request, so a result
// appears in the next cycle. Events that produce no result still update state.
// The request side is stalled only while a response sits in the output
// register and the consumer stalls it.
// Reset (synchronous) clears touch state, the output valid and loads the CSR
// defaults (swipe 50, hold 12).
// ----------------------------------------------------------------------------
`default_nettype none

module touch_gesture_classifier_top
   import tgc_pkg::*;
#(
   parameter int TIMER_BITS = TGC_TIMER_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // request channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire tgc_req_type               req_data,
   // response channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output tgc_rsp_type                    rsp_data,
   // csr write port
   input  wire logic                      csr_wr_en,
   input  wire logic                      csr_index,
   input  wire logic [TGC_CSR_BITS-1:0]   csr_wdata
);

   localparam int CW   = TGC_COORD_BITS;
   // Common width for timer vs. hold_ticks compares
   localparam int CmpW = (TIMER_BITS > TGC_HOLD_BITS) ? TIMER_BITS : TGC_HOLD_BITS;

   // ---------------------------------------------------------------- csrs
   logic [TGC_SWIPE_BITS-1:0] swipe_distance_ff;
   logic [TGC_HOLD_BITS-1:0]  hold_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         swipe_distance_ff <= TGC_SWIPE_RESET;
         hold_ticks_ff     <= TGC_HOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            TGC_CSR_SWIPE_DISTANCE: swipe_distance_ff <= csr_wdata[TGC_SWIPE_BITS-1:0];
            TGC_CSR_HOLD_TICKS:     hold_ticks_ff     <= csr_wdata[TGC_HOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   logic                  active_ff,  active_in;
   logic                  drag_ff,    drag_in;
   logic [CW-1:0]         first_x_ff, first_x_in;
   logic [CW-1:0]         first_y_ff, first_y_in;
   logic [CW-1:0]         last_x_ff,  last_x_in;
   logic [CW-1:0]         last_y_ff,  last_y_in;
   logic [TIMER_BITS-1:0] held_ff,    held_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   tgc_rsp_type           rsp_data_ff,  rsp_data_in;

   logic                  req_accept;
   logic                  emit;
   logic [2:0]            gesture;

   // Within one pixel in both axes
   function automatic logic near_pt(input logic [CW-1:0] ax, input logic [CW-1:0] ay,
                                    input logic [CW-1:0] bx, input logic [CW-1:0] by);
      logic [CW:0] dx;
      logic [CW:0] dy;
      logic        nx;
      logic        ny;
      dx = {1'b0, ax} - {1'b0, bx};
      dy = {1'b0, ay} - {1'b0, by};
      nx = (dx == '0) || (dx == (CW+1)'(1)) || (dx == '1);
      ny = (dy == '0) || (dy == (CW+1)'(1)) || (dy == '1);
      return nx && ny;
   endfunction

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   logic [CW:0]           dy_move;
   logic [CW-1:0]         dy_abs;
   logic                  up_move;
   logic [TIMER_BITS-1:0] held_inc;
   logic                  held_le_hold;
   logic                  inc_gt_hold;

   always_comb begin
      // vertical travel for a move, relative to the latched start
      dy_move = {1'b0, req_data.y_pos} - {1'b0, first_y_ff};
      up_move = !dy_move[CW] && (dy_move != '0);
      dy_abs  = dy_move[CW] ? (CW)'(-dy_move) : dy_move[CW-1:0];

      held_inc     = (held_ff == '1) ? held_ff : held_ff + 1'b1;
      held_le_hold = CmpW'(held_ff) <= CmpW'(hold_ticks_ff);
      inc_gt_hold  = CmpW'(held_inc) > CmpW'(hold_ticks_ff);

      active_in  = active_ff;
      drag_in    = drag_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      held_in    = held_ff;
      emit       = 1'b0;
      gesture    = TGC_GEST_HOLD;

      case (req_data.cmd)
         TGC_CMD_BEGIN: begin
            first_x_in = req_data.x_pos;
            first_y_in = req_data.y_pos;
            last_x_in  = req_data.x_pos;
            last_y_in  = req_data.y_pos;
            held_in    = '0;
            active_in  = 1'b1;
         end
         TGC_CMD_MOVE: begin
            last_x_in = req_data.x_pos;
            last_y_in = req_data.y_pos;
            active_in = 1'b1;
            drag_in   = 1'b1;
            if (dy_abs > swipe_distance_ff) begin
               emit    = 1'b1;
               gesture = up_move ? TGC_GEST_UP : TGC_GEST_DOWN;
            end
         end
         TGC_CMD_END: begin
            drag_in   = 1'b0;
            last_x_in = req_data.x_pos;
            last_y_in = req_data.y_pos;
            active_in = 1'b0;
            emit      = 1'b1;
            // near check uses the new end point
            if (held_le_hold &&
                near_pt(first_x_ff, first_y_ff, req_data.x_pos, req_data.y_pos)) begin
               gesture = TGC_GEST_TAP;
            end else begin
               gesture = TGC_GEST_ENDED;
            end
         end
         default: begin // tick; timer runs even with no touch
            held_in = held_inc;
            if (active_ff && inc_gt_hold &&
                (near_pt(first_x_ff, first_y_ff, last_x_ff, last_y_ff) || drag_ff)) begin
               drag_in = 1'b1;
               held_in = '0;
               emit    = 1'b1;
               gesture = TGC_GEST_HOLD;
            end
         end
      endcase

      rsp_data_in.gesture = gesture;
      rsp_data_in.start_x = first_x_in;
      rsp_data_in.start_y = first_y_in;
      rsp_data_in.end_x   = last_x_in;
      rsp_data_in.end_y   = last_y_in;

      // output register: drain on take, load on a result-bearing transaction
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         drag_ff      <= 1'b0;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            active_ff  <= active_in;
            drag_ff    <= drag_in;
            first_x_ff <= first_x_in;
            first_y_ff <= first_y_in;
            last_x_ff  <= last_x_in;
            last_y_ff  <= last_y_in;
            held_ff    <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### verif/touch_gesture_classifier_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top_test
// Self-checking bench for the touch gesture classifier. A predictor tracks the
// touch state and thresholds, queues the gesture each event should raise, and
// compares every accepted response field by field. Stimulus is a directed
// opening followed by random begin/move/tick/end sequences under several
// threshold settings and idle patterns.
// ----------------------------------------------------------------------------

module touch_gesture_classifier_top_test;
   import tgc_pkg::*;

   // Generous bound: about 1k events, each under the heaviest idle pattern.
   localparam int CYCLE_LIMIT = 50000;

   // -------------------------------------------------------------------------
   // Gesture predictor: own copy of the touch state and thresholds, plus the
   // queue of gestures still owed by the block.
   // -------------------------------------------------------------------------
   class gesture_predictor;
      logic [TGC_SWIPE_BITS-1:0] swipe_distance;
      logic [TGC_HOLD_BITS-1:0]  hold_ticks;
      logic                      touch_active;
      logic                      dragging;
      logic [TGC_COORD_BITS-1:0] first_x, first_y, last_x, last_y;
      logic [TGC_TIMER_BITS-1:0] held_time;
      tgc_rsp_type               pending_gestures[$];
      int                        mismatches;

      function new();
         swipe_distance = TGC_SWIPE_RESET;
         hold_ticks     = TGC_HOLD_RESET;
         touch_active   = 1'b0;
         dragging       = 1'b0;
         first_x        = '0;
         first_y        = '0;
         last_x         = '0;
         last_y         = '0;
         held_time      = '0;
         mismatches     = 0;
      endfunction

      function void write_register(logic index, logic [TGC_CSR_BITS-1:0] value);
         if (index == TGC_CSR_SWIPE_DISTANCE) begin
            swipe_distance = value[TGC_SWIPE_BITS-1:0];
         end else begin
            hold_ticks = value[TGC_HOLD_BITS-1:0];
         end
      endfunction

      function logic [TGC_COORD_BITS-1:0] travel(logic [TGC_COORD_BITS-1:0] a,
                                                 logic [TGC_COORD_BITS-1:0] b);
         return (a >= b) ? a - b : b - a;
      endfunction

      function bit still_near();
         return travel(first_x, last_x) <= 1 && travel(first_y, last_y) <= 1;
      endfunction

      function void queue_gesture(logic [2:0] code);
         tgc_rsp_type rsp;
         rsp.gesture = code;
         rsp.start_x = first_x;
         rsp.start_y = first_y;
         rsp.end_x   = last_x;
         rsp.end_y   = last_y;
         pending_gestures.push_back(rsp);
      endfunction

      function void note_event(tgc_req_type ev);
         case (ev.cmd)
            TGC_CMD_BEGIN: begin
               first_x      = ev.x_pos;
               first_y      = ev.y_pos;
               last_x       = ev.x_pos;
               last_y       = ev.y_pos;
               held_time    = '0;
               touch_active = 1'b1;
            end
            TGC_CMD_MOVE: begin
               last_x       = ev.x_pos;
               last_y       = ev.y_pos;
               touch_active = 1'b1;
               dragging     = 1'b1;
               if (travel(last_y, first_y) > swipe_distance) begin
                  queue_gesture((last_y > first_y) ? TGC_GEST_UP : TGC_GEST_DOWN);
               end
            end
            TGC_CMD_END: begin
               dragging = 1'b0;
               last_x   = ev.x_pos;
               last_y   = ev.y_pos;
               if (held_time <= hold_ticks && still_near()) begin
                  queue_gesture(TGC_GEST_TAP);
               end else begin
                  queue_gesture(TGC_GEST_ENDED);
               end
               touch_active = 1'b0;
            end
            TGC_CMD_TICK: begin
               // timer saturates and runs even with no touch down
               if (held_time != '1) held_time++;
               if (touch_active && held_time > hold_ticks && (still_near() || dragging)) begin
                  dragging  = 1'b1;
                  held_time = '0;
                  queue_gesture(TGC_GEST_HOLD);
               end
            end
         endcase
      endfunction

      function int outstanding();
         return pending_gestures.size();
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      task compare_field(string name, logic [TGC_COORD_BITS-1:0] got,
                         logic [TGC_COORD_BITS-1:0] want);
         if (got !== want) begin
            report($sformatf("%s got %0d, want %0d", name, got, want));
         end
      endtask

      task check_gesture(tgc_rsp_type rsp);
         tgc_rsp_type want;
         if (pending_gestures.size() == 0) begin
            report($sformatf("unexpected response, gesture %0d", rsp.gesture));
         end else begin
            want = pending_gestures.pop_front();
            compare_field("gesture", rsp.gesture, want.gesture);
            compare_field("start_x", rsp.start_x, want.start_x);
            compare_field("start_y", rsp.start_y, want.start_y);
            compare_field("end_x", rsp.end_x, want.end_x);
            compare_field("end_y", rsp.end_y, want.end_y);
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   tgc_req_type             req_data;
   logic                    rsp_valid;
   logic                    rsp_stall;
   tgc_rsp_type             rsp_data;
   logic                    csr_wr_en;
   logic                    csr_index;
   logic [TGC_CSR_BITS-1:0] csr_wdata;

   gesture_predictor predictor = new();

   int send_idle_pct;
   int recv_idle_pct;
   int events_sent;
   int cycle_count;

   touch_gesture_classifier_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a missing response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Consumer side: stall pattern follows the current idle percentage.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Transaction monitor. Values read right after the edge are the ones the
   // block saw at that edge, since every input changes by nonblocking update.
   // A response at this edge always belongs to a request from an earlier one.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) predictor.check_gesture(rsp_data);
         if (req_valid && !req_stall) predictor.note_event(req_data);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic tgc_req_type make_event(logic [1:0] cmd,
                                              logic [TGC_COORD_BITS-1:0] x,
                                              logic [TGC_COORD_BITS-1:0] y);
      tgc_req_type ev;
      ev.cmd   = cmd;
      ev.x_pos = x;
      ev.y_pos = y;
      return ev;
   endfunction

   function automatic logic [TGC_COORD_BITS-1:0] any_coord();
      return TGC_COORD_BITS'($urandom_range(4095));
   endfunction

   // Same point, one pixel off either way, or anywhere: exercises the
   // tap/hold nearness window of one pixel.
   function automatic logic [TGC_COORD_BITS-1:0] jitter(logic [TGC_COORD_BITS-1:0] base);
      case ($urandom_range(3))
         0: return base;
         1: return base + 1'b1;
         2: return base - 1'b1;
         default: return any_coord();
      endcase
   endfunction

   // Vertical travel of threshold-1, threshold or threshold+1, up or down,
   // so both sides of the strict swipe compare get hit.
   function automatic logic [TGC_COORD_BITS-1:0] swipe_target(logic [TGC_COORD_BITS-1:0] base);
      logic [TGC_COORD_BITS-1:0] reach;
      reach = predictor.swipe_distance + TGC_COORD_BITS'($urandom_range(2)) - 1'b1;
      case ($urandom_range(3))
         0: return base + reach;
         1: return base - reach;
         default: return any_coord();
      endcase
   endfunction

   // One request transaction with optional idle cycles ahead of it. Returns
   // at the edge that accepted it, with req_valid still high.
   task automatic send_event(tgc_req_type ev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      events_sent++;
   endtask

   // Sender holds off until every owed gesture has arrived, then lets the
   // pipeline settle for events that raise nothing.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (predictor.outstanding() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Both thresholds are written back to back, only with the block quiet.
   task automatic set_thresholds(logic [TGC_SWIPE_BITS-1:0] swipe,
                                 logic [TGC_HOLD_BITS-1:0] hold);
      wait_quiet();
      csr_wr_en <= 1'b1;
      csr_index <= TGC_CSR_SWIPE_DISTANCE;
      csr_wdata <= TGC_CSR_BITS'(swipe);
      @(posedge clock);
      csr_index <= TGC_CSR_HOLD_TICKS;
      csr_wdata <= TGC_CSR_BITS'(hold);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      predictor.write_register(TGC_CSR_SWIPE_DISTANCE, TGC_CSR_BITS'(swipe));
      predictor.write_register(TGC_CSR_HOLD_TICKS, TGC_CSR_BITS'(hold));
   endtask

   // Well-formed touch: begin, a few moves and tick bursts, then end.
   task automatic play_gesture();
      logic [TGC_COORD_BITS-1:0] bx;
      logic [TGC_COORD_BITS-1:0] by;
      int                        steps;
      int                        ticks;
      bx    = any_coord();
      by    = any_coord();
      steps = $urandom_range(4);
      send_event(make_event(TGC_CMD_BEGIN, bx, by));
      repeat (steps) begin
         case ($urandom_range(2))
            0: send_event(make_event(TGC_CMD_MOVE, jitter(bx), swipe_target(by)));
            1: send_event(make_event(TGC_CMD_MOVE, jitter(bx), jitter(by)));
            default: begin
               ticks = $urandom_range(1, 16);
               repeat (ticks) send_event(make_event(TGC_CMD_TICK, any_coord(), any_coord()));
            end
         endcase
      end
      send_event(make_event(TGC_CMD_END, jitter(bx), jitter(by)));
   endtask

   // Mostly proper gestures; the rest is stray events in any order.
   task automatic run_phase(int count);
      int first_event;
      first_event = events_sent;
      while (events_sent - first_event < count) begin
         if ($urandom_range(99) < 85) begin
            play_gesture();
         end else begin
            send_event(make_event(2'($urandom_range(3)), any_coord(), any_coord()));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = TGC_CSR_SWIPE_DISTANCE;
      csr_wdata     = '0;
      send_idle_pct = 12;
      recv_idle_pct = 60;
      events_sent   = 0;
      cycle_count   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening at reset thresholds (swipe 50, hold 12).
      // End and move with no begin run off the reset state.
      send_event(make_event(TGC_CMD_END, 12'd4095, 12'd4095));
      send_event(make_event(TGC_CMD_MOVE, 12'd0, 12'd0));
      // Tap with the end point one pixel off diagonally.
      send_event(make_event(TGC_CMD_BEGIN, 12'd4095, 12'd4095));
      send_event(make_event(TGC_CMD_END, 12'd4094, 12'd4094));
      // Swipe up just past the threshold, then a tap back at the start.
      send_event(make_event(TGC_CMD_BEGIN, 12'd0, 12'd0));
      send_event(make_event(TGC_CMD_MOVE, 12'd1, 12'd51));
      send_event(make_event(TGC_CMD_MOVE, 12'd0, 12'd50));
      send_event(make_event(TGC_CMD_END, 12'd1, 12'd1));
      // Swipe down, then an end two pixels off: touch ended.
      send_event(make_event(TGC_CMD_BEGIN, 12'd2048, 12'd3000));
      send_event(make_event(TGC_CMD_MOVE, 12'd2049, 12'd2949));
      send_event(make_event(TGC_CMD_END, 12'd2050, 12'd3000));
      // Hold: the thirteenth tick passes the reset hold limit.
      send_event(make_event(TGC_CMD_BEGIN, 12'd100, 12'd100));
      repeat (13) send_event(make_event(TGC_CMD_TICK, 12'd4095, 12'd0));
      send_event(make_event(TGC_CMD_END, 12'd100, 12'd100));
      // Full-range swipe down, then a tick with no touch down.
      send_event(make_event(TGC_CMD_BEGIN, 12'd0, 12'd4095));
      send_event(make_event(TGC_CMD_MOVE, 12'd4095, 12'd0));
      send_event(make_event(TGC_CMD_END, 12'd4095, 12'd0));
      send_event(make_event(TGC_CMD_TICK, 12'd0, 12'd4095));

      // Sender light, consumer heavy.
      run_phase(150);
      set_thresholds(12'd0, 16'd0);
      run_phase(150);

      // Sender heavy, consumer light.
      send_idle_pct = 60;
      recv_idle_pct = 12;
      set_thresholds(12'd4095, 16'd65535);
      run_phase(150);
      set_thresholds(TGC_SWIPE_BITS'($urandom_range(1, 200)),
                     TGC_HOLD_BITS'($urandom_range(20)));
      run_phase(150);

      // No idling on either side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_thresholds(12'd20, 16'd3);
      run_phase(150);
      set_thresholds(TGC_SWIPE_BITS'($urandom_range(300)),
                     TGC_HOLD_BITS'($urandom_range(15)));
      run_phase(150);

      wait_quiet();
      if (predictor.outstanding() != 0) begin
         predictor.report("gestures still owed at the end");
      end
      if (predictor.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### touch_gesture_classifier_top.f
sv/tgc_pkg.sv
sv/touch_gesture_classifier_top.sv
verif/touch_gesture_classifier_top_test.sv
